@@ src/ics_pkg.sv @@
// Shared types, constants and the one's-complement add for the streaming checksum.
package ics_pkg;

  // Chunk queue between the front and the back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [15:0] SUM_MASK  = 16'hffff;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;

  // One queued request: the folded partial sum of a chunk and its end flag
  typedef struct packed {
    logic [15:0] part_sum;
    logic        last;
  } q_entry_t;

  // 16-bit add with end-around carry
  function automatic logic [15:0] add_ones(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    begin
      s = {1'b0, acc} + {1'b0, word};
      add_ones = s[15:0] + {15'b0, s[16]};
    end
  endfunction

endpackage

@@ src/ics_front.sv @@
// Front end: accepts chunks, pairs bytes across chunk boundaries, folds the chunk's words.
module ics_front #(
  parameter int LANE_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         in_data_word,
  input  logic [3:0]          in_byte_count,
  input  logic                in_last_chunk,
  input  logic                q_full,
  output logic                q_push,
  output ics_pkg::q_entry_t   q_entry
);

  localparam int LIM = (LANE_BYTES > 8) ? 8 : LANE_BYTES;
  localparam logic [3:0] LIM_CNT = 4'(LIM);

  logic        odd_r, odd_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [3:0]  cnt, n, keep_n;
  logic [7:0]  lane [0:7];
  logic [7:0]  s    [0:8];
  logic [7:0]  sm   [0:8];
  logic [18:0] wsum;
  logic [16:0] f1;
  logic [15:0] f2;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Byte alignment: a pending odd byte shifts this chunk down by one lane
  always_comb begin
    cnt    = (in_byte_count > LIM_CNT) ? LIM_CNT : in_byte_count;
    n      = cnt + {3'b0, odd_r};
    // on a non-final chunk a trailing odd byte is held back, not added
    keep_n = in_last_chunk ? n : {n[3:1], 1'b0};
    for (int i = 0; i < 8; i++) begin
      lane[i] = in_data_word[63 - 8*i -: 8];
    end
    s[0] = odd_r ? pend_r : lane[0];
    for (int i = 1; i < 8; i++) begin
      s[i] = odd_r ? lane[i-1] : lane[i];
    end
    s[8] = odd_r ? lane[7] : 8'h00;
    for (int i = 0; i < 9; i++) begin
      sm[i] = (4'(i) < keep_n) ? s[i] : 8'h00;
    end
  end

  // Chunk word sum, folded twice back to 16 bits
  always_comb begin
    wsum = '0;
    for (int k = 0; k < 4; k++) begin
      wsum = wsum + 19'({sm[2*k], sm[2*k+1]});
    end
    wsum = wsum + 19'({sm[8], 8'h00});
    f1   = 17'(wsum[15:0]) + 17'(wsum[18:16]);
    f2   = f1[15:0] + 16'(f1[16]);
  end

  assign q_entry.part_sum = f2 & ics_pkg::SUM_MASK;
  assign q_entry.last     = in_last_chunk;

  // Odd byte carried into the next chunk
  always_comb begin
    odd_nxt  = odd_r;
    pend_nxt = pend_r;
    if (q_push) begin
      if (in_last_chunk || !n[0]) begin
        odd_nxt  = 1'b0;
        pend_nxt = 8'h00;
      end else begin
        odd_nxt  = 1'b1;
        pend_nxt = s[n - 4'd1] & ics_pkg::BYTE_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_r  <= 1'b0;
      pend_r <= 8'h00;
    end else begin
      odd_r  <= odd_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

@@ src/ics_fifo.sv @@
// Short request queue between the front and back ends.
module ics_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ics_pkg::q_entry_t push_data,
  input  logic              pop,
  output ics_pkg::q_entry_t head,
  output logic              empty,
  output logic              full
);

  ics_pkg::q_entry_t                mem [0:ics_pkg::QDEPTH-1];
  logic [ics_pkg::QAW-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [ics_pkg::QAW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [ics_pkg::QAW:0]            count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (ics_pkg::QAW+1)'(ics_pkg::QDEPTH));
  assign head  = mem[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/ics_back.sv @@
// Back end: accumulates chunk sums and emits the inverted checksum at message end.
module ics_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ics_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_checksum
);

  logic [15:0] sum_r, sum_nxt;
  logic [15:0] chk_r, chk_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] sum_new;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;
  // Non-final requests never wait on the output side
  assign q_pop     = !q_empty && (!q_head.last || slot_free);
  assign sum_new   = ics_pkg::add_ones(sum_r, q_head.part_sum);

  always_comb begin
    sum_nxt       = sum_r;
    chk_nxt       = chk_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop) begin
      if (q_head.last) begin
        sum_nxt       = 16'h0000;
        chk_nxt       = ~sum_new & ics_pkg::SUM_MASK;
        out_valid_nxt = 1'b1;
      end else begin
        sum_nxt = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = chk_r;

endmodule

@@ src/internet_checksum_stream.sv @@
// Top level of the streaming Internet checksum: front end, request queue, back end.
//
//   channel | ports                                              | role
//   in      | in_valid, in_ready, in_data_word, in_byte_count,   | chunk of up to 8 bytes
//           | in_last_chunk                                      |
//   out     | out_valid, out_ready, out_checksum                 | one checksum per message
//
// One chunk per clock is accepted while the four-entry queue has room.
// A chunk's sum is written into the queue on acceptance and reaches the accumulator when it is read out;
// the checksum appears in the output register the cycle after the last chunk leaves the queue.
// Synchronous active-low reset clears the sum, odd-byte state, queue and output valid.
// A stalled output only holds back final chunks; the queue absorbs the gap.
module internet_checksum_stream #(
  parameter int LANE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_chunk,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_checksum
);

  logic              q_push, q_pop, q_empty, q_full;
  ics_pkg::q_entry_t q_in, q_head;

  ics_front #(
    .LANE_BYTES(LANE_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_chunk (in_last_chunk),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  ics_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ics_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_checksum (out_checksum)
  );

  // Cross-module checks
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_ready) else $error("input taken with queue full");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !q_empty) else $error("accepted chunk missing from queue");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.last) |=> out_valid) else $error("final request gave no checksum");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop && q_head.last)) else $error("checksum without final request");

endmodule

@@ test/checksum_checker.sv @@
// Checker for the streaming checksum: predicts each message's checksum and compares results.
module checksum_checker #(
  parameter int LANE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_chunk,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_checksum,
  output int          failures,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted message state
  logic [15:0] sum_acc;
  logic        held_valid;
  logic [7:0]  held_byte;

  // Checksums of completed messages, oldest first
  logic [15:0] checksum_q[$];

  // One's-complement add: widen, then fold the carry back in
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] t;
    t = 32'(a) + 32'(b);
    t = (t & 32'h0000ffff) + (t >> 16);
    return t[15:0];
  endfunction

  // Fold one accepted request into the running sum; close the message on its last chunk
  task automatic absorb_chunk(input logic [63:0] data, input logic [3:0] cnt,
                              input logic last);
    int         lim;
    int         n;
    logic [7:0] b;
    lim = (LANE_BYTES < 8) ? LANE_BYTES : 8;
    n = (int'(cnt) > lim) ? lim : int'(cnt);
    for (int i = 0; i < n; i++) begin
      b = data[63 - 8*i -: 8];
      // pair with a waiting byte, else hold this one (a zero byte is tracked by its flag)
      if (held_valid) begin
        sum_acc = ones_add(sum_acc, {held_byte, b});
        held_valid = 1'b0;
        held_byte = 8'h00;
      end else begin
        held_byte = b;
        held_valid = 1'b1;
      end
    end
    if (last) begin
      // leftover odd byte goes in as the high half of a padded word
      if (held_valid) sum_acc = ones_add(sum_acc, {held_byte, 8'h00});
      checksum_q.push_back(~sum_acc);
      sum_acc = 16'h0000;
      held_valid = 1'b0;
      held_byte = 8'h00;
    end
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk) begin : watch
    logic [15:0] want;
    if (!rst_n) begin
      sum_acc = 16'h0000;
      held_valid = 1'b0;
      held_byte = 8'h00;
      checksum_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (checksum_q.size() == 0) begin
          $display("%0t: checksum expected none, got %h", $time, out_checksum);
          failures++;
        end else begin
          want = checksum_q.pop_front();
          if (out_checksum !== want) begin
            $display("%0t: checksum expected %h, got %h", $time, want, out_checksum);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) absorb_chunk(in_data_word, in_byte_count, in_last_chunk);
    end
    outstanding = checksum_q.size();
  end

endmodule

@@ test/internet_checksum_stream_tb.sv @@
// Testbench top for the streaming checksum: clock, reset, request stimulus and verdict.
module internet_checksum_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES        = 8;
  localparam int ITEMS        = 950;
  localparam int PRESS_AT     = 300;   // requests seen before the long output hold-off
  localparam int PRESS_CYCLES = 400;
  localparam int PRESS_BURST  = 80;    // back-to-back requests offered during the hold-off
  localparam int WATCHDOG     = 4000;
  localparam int DRAIN        = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_data_word;
  logic [3:0]  in_byte_count;
  logic        in_last_chunk;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_checksum;

  int failures;
  int outstanding;
  int sent_cnt = 0;
  bit calm_run = 1'b0;

  internet_checksum_stream #(.LANE_BYTES(LANES)) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_chunk (in_last_chunk),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_checksum  (out_checksum)
  );

  checksum_checker #(.LANE_BYTES(LANES)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_chunk (in_last_chunk),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_checksum  (out_checksum),
    .failures      (failures),
    .outstanding   (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_chunk(input logic [63:0] data, input logic [3:0] cnt, input logic last);
    int gap;
    gap = (calm_run || (sent_cnt >= PRESS_AT && sent_cnt < PRESS_AT + PRESS_BURST))
          ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= data;
    in_byte_count <= cnt;
    in_last_chunk <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  // Receiver: random ready runs and stalls, plus one long hold-off to back up the queue
  initial begin : receiver
    int run_left;
    int stall_left;
    int seen;
    bit pressed;
    run_left = 0;
    stall_left = 0;
    seen = 0;
    pressed = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && in_valid && in_ready) seen++;
      if (!pressed && seen >= PRESS_AT) begin
        pressed = 1'b1;
        run_left = 0;
        stall_left = PRESS_CYCLES;
      end
      if (run_left == 0 && stall_left == 0) begin
        run_left = $urandom_range(1, 60);
        stall_left = idle_len();
      end
      if (run_left > 0) begin
        run_left--;
        out_ready <= 1'b1;
      end else begin
        stall_left--;
        out_ready <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("internet_checksum_stream: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int          nchunks;
    int          r;
    logic [63:0] d;
    logic [3:0]  c;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_word  <= 64'h0;
    in_byte_count <= 4'h0;
    in_last_chunk <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty message
    send_chunk(64'h0, 4'd0, 1'b1);
    // all ones: sum stays at negative zero, checksum 0
    send_chunk(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
    // all zeros
    send_chunk(64'h0, 4'd8, 1'b1);
    // nonzero words summing to negative zero
    send_chunk(64'h0001_fffe_0000_0000, 4'd4, 1'b1);
    // textbook byte sequence
    send_chunk(64'h0001_f203_f4f5_f6f7, 4'd8, 1'b1);
    // single odd byte padded on the last chunk
    send_chunk(64'hab00_0000_0000_0000, 4'd1, 1'b1);
    // odd zero byte carried into the next chunk
    send_chunk(64'h1234_00ff_ffff_ffff, 4'd3, 1'b0);
    send_chunk(64'h5600_0000_0000_0000, 4'd1, 1'b1);
    // count above the lane width
    send_chunk(64'hdead_beef_0123_4567, 4'd15, 1'b1);
    // empty chunks with a byte waiting, then an empty last chunk
    send_chunk(64'ha5ff_ffff_ffff_ffff, 4'd1, 1'b0);
    send_chunk(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0);
    send_chunk(64'h1234_5678_9abc_def0, 4'd0, 1'b1);
    // odd counts pairing across chunk boundaries, oversized counts mid-message
    send_chunk(64'hfedc_ba98_7654_3210, 4'd5, 1'b0);
    send_chunk(64'h8899_aabb_ccdd_eeff, 4'd7, 1'b0);
    send_chunk(64'h0f1e_2d3c_4b5a_6978, 4'd3, 1'b0);
    send_chunk(64'hffff_0000_ffff_0000, 4'd9, 1'b0);
    send_chunk(64'h7fff_8000_7fff_8000, 4'd12, 1'b1);
    send_chunk(64'h8000_0000_0000_0001, 4'd8, 1'b0);
    send_chunk(64'h0123_4567_89ab_cdef, 4'd8, 1'b1);

    // Random messages: mostly short, a few long
    while (sent_cnt < ITEMS) begin
      nchunks = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 24);
      calm_run = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < nchunks; k++) begin
        r = $urandom_range(0, 99);
        if (r < 50) c = 4'd8;
        else if (r < 85) c = 4'($urandom_range(0, 8));
        else c = 4'($urandom_range(9, 15));
        r = $urandom_range(0, 99);
        if (r < 80) d = {$urandom, $urandom};
        else if (r < 88) d = '1;
        else if (r < 94) d = '0;
        else d = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        send_chunk(d, c, k == nchunks - 1);
      end
    end
    in_valid <= 1'b0;
    calm_run = 1'b0;

    // let the checker count the last request before reading its backlog
    @(posedge clk);
    // wait for every checksum, then a short drain for anything extra
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (failures == 0) begin
      $display("internet_checksum_stream: match");
    end else begin
      $display("internet_checksum_stream: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ics_pkg.sv
src/ics_front.sv
src/ics_fifo.sv
src/ics_back.sv
src/internet_checksum_stream.sv
test/checksum_checker.sv
test/internet_checksum_stream_tb.sv
